@@ src/mkm_pkg.sv @@
// ============================================================================
// mkm_pkg: shared types and constants for the multi-keyword matcher
// Widths, register index codes and the front/back transaction struct.
// ============================================================================
package mkm_pkg;

    localparam int KW_COUNT      = 4;                    // keyword slots
    localparam int KW_REGS       = 4;                    // keyword registers present
    localparam int KW_LEN_MAX    = 8;                    // bytes per keyword
    localparam int BYTE_W        = 8;
    localparam int POS_W         = 32;
    localparam int LEN_W         = 4;                    // one length nibble
    localparam int LENS_W        = LEN_W * KW_REGS;
    localparam int KW_W          = KW_LEN_MAX * BYTE_W;
    localparam int KW_BYTE_IDX_W = (KW_LEN_MAX > 1) ? $clog2(KW_LEN_MAX) : 1;
    localparam int SEEN_W        = $clog2(KW_LEN_MAX + 2);
    localparam int HIST_DEPTH    = KW_LEN_MAX - 1;
    localparam int HIST_W        = HIST_DEPTH * BYTE_W;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 64;
    localparam int Q_DEPTH       = 4;
    localparam int Q_PTR_W       = $clog2(Q_DEPTH);
    localparam int Q_CNT_W       = $clog2(Q_DEPTH + 1);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KEYWORD_A       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEYWORD_B       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEYWORD_C       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEYWORD_D       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KEYWORD_LENGTHS = 3'd4;

    // text window handed from front to back: byte j back sits at [j*8 +: 8]
    typedef struct packed {
        logic [KW_W-1:0]   window;
        logic [SEEN_W-1:0] avail;   // bytes of this text including current, max 9
        logic [POS_W-1:0]  pos;
    } t_window;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

@@ src/mkm_front.sv @@
// ============================================================================
// mkm_front: text history and position tracking
// Builds the window of recent bytes for each accepted text byte.
// ============================================================================
module mkm_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_accept,
    input  logic [mkm_pkg::BYTE_W-1:0] i_text_byte,
    input  logic                     i_text_start,
    output mkm_pkg::t_window         o_item
);

    logic [mkm_pkg::HIST_W-1:0] r_hist, n_hist;
    logic [mkm_pkg::SEEN_W-1:0] r_seen, n_seen;
    logic [mkm_pkg::POS_W-1:0]  r_pos,  n_pos;

    logic [mkm_pkg::HIST_W-1:0] hist_eff;
    logic [mkm_pkg::SEEN_W-1:0] seen_eff;
    logic [mkm_pkg::POS_W-1:0]  pos_eff;

    // a new text clears history before the byte is used
    always_comb begin
        hist_eff = i_text_start ? '0 : r_hist;
        seen_eff = i_text_start ? '0 : r_seen;
        pos_eff  = i_text_start ? '0 : r_pos;

        o_item.window = {hist_eff, i_text_byte};
        o_item.avail  = seen_eff + mkm_pkg::SEEN_W'(1);
        o_item.pos    = pos_eff;

        n_hist = o_item.window[mkm_pkg::HIST_W-1:0];
        n_seen = (seen_eff < mkm_pkg::SEEN_W'(mkm_pkg::KW_LEN_MAX))
                 ? seen_eff + mkm_pkg::SEEN_W'(1) : seen_eff;
        n_pos  = pos_eff + mkm_pkg::POS_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist <= '0;
            r_seen <= '0;
            r_pos  <= '0;
        end else if (i_accept) begin
            r_hist <= n_hist;
            r_seen <= n_seen;
            r_pos  <= n_pos;
        end
    end

    a_start_restarts_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_text_start) |=> (r_pos == mkm_pkg::POS_W'(1)))
        else $error("position not restarted by text start");

endmodule

@@ src/mkm_queue.sv @@
// ============================================================================
// mkm_queue: short queue between front and back
// Holds text windows so that the input and the compare side stall apart.
// ============================================================================
module mkm_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  mkm_pkg::t_window   i_data,
    input  logic               i_pop,
    output mkm_pkg::t_window   o_data,
    output mkm_pkg::t_q_status o_status
);

    mkm_pkg::t_window             r_mem [mkm_pkg::Q_DEPTH];
    logic [mkm_pkg::Q_PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [mkm_pkg::Q_CNT_W-1:0]  r_count;
    logic                         do_push, do_pop;

    always_comb begin
        o_status.full  = (r_count == mkm_pkg::Q_CNT_W'(mkm_pkg::Q_DEPTH));
        o_status.empty = (r_count == '0);
        do_push        = i_push && !o_status.full;
        do_pop         = i_pop && !o_status.empty;
        o_data         = r_mem[r_rd_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + mkm_pkg::Q_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + mkm_pkg::Q_PTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + mkm_pkg::Q_CNT_W'(1);
                2'b01:   r_count <= r_count - mkm_pkg::Q_CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= mkm_pkg::Q_CNT_W'(mkm_pkg::Q_DEPTH))
        else $error("queue count beyond depth");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_status.empty |-> !i_pop)
        else $error("back popped an empty queue");

endmodule

@@ src/mkm_match.sv @@
// ============================================================================
// mkm_match: keyword registers, parallel compare and result register
// Compares every keyword against the window at the queue head.
// ============================================================================
module mkm_match (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [mkm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mkm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  mkm_pkg::t_window               i_item,
    input  mkm_pkg::t_q_status             i_q_status,
    output logic                           o_q_pop,
    input  logic                           i_pop,
    output logic                           o_empty,
    output logic [mkm_pkg::POS_W-1:0]      o_match_position,
    output logic [mkm_pkg::KW_COUNT-1:0]   o_match_mask
);

    logic [mkm_pkg::KW_W-1:0]     r_kw [mkm_pkg::KW_REGS];
    logic [mkm_pkg::LENS_W-1:0]   r_lens;
    logic                         r_out_valid;
    logic [mkm_pkg::POS_W-1:0]    r_out_pos;
    logic [mkm_pkg::KW_COUNT-1:0] r_out_mask;

    logic [mkm_pkg::KW_COUNT-1:0] mask;
    logic                         out_free, load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < mkm_pkg::KW_REGS; k++) begin
                r_kw[k] <= '0;
            end
            r_lens <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mkm_pkg::REG_KEYWORD_A:       r_kw[0] <= i_cfg_data[mkm_pkg::KW_W-1:0];
                mkm_pkg::REG_KEYWORD_B:       r_kw[1] <= i_cfg_data[mkm_pkg::KW_W-1:0];
                mkm_pkg::REG_KEYWORD_C:       r_kw[2] <= i_cfg_data[mkm_pkg::KW_W-1:0];
                mkm_pkg::REG_KEYWORD_D:       r_kw[3] <= i_cfg_data[mkm_pkg::KW_W-1:0];
                mkm_pkg::REG_KEYWORD_LENGTHS: r_lens  <= i_cfg_data[mkm_pkg::LENS_W-1:0];
                default: ;
            endcase
        end
    end

    // keyword byte (len-1-j) against text byte j back; all in parallel
    always_comb begin
        logic [mkm_pkg::LEN_W-1:0] nib;
        logic [mkm_pkg::LEN_W-1:0] len_c;
        logic [mkm_pkg::LEN_W-1:0] bidx;
        logic                      hit;
        mask = '0;
        for (int k = 0; k < mkm_pkg::KW_COUNT; k++) begin
            if (k < mkm_pkg::KW_REGS) begin
                nib   = r_lens[k*mkm_pkg::LEN_W +: mkm_pkg::LEN_W];
                len_c = (nib > mkm_pkg::LEN_W'(mkm_pkg::KW_LEN_MAX))
                        ? mkm_pkg::LEN_W'(mkm_pkg::KW_LEN_MAX) : nib;
                // length nibble and byte count share one width
                hit   = (len_c != '0) && (len_c <= i_item.avail);
                for (int j = 0; j < mkm_pkg::KW_LEN_MAX; j++) begin
                    bidx = len_c - mkm_pkg::LEN_W'(1) - mkm_pkg::LEN_W'(j);
                    if (mkm_pkg::LEN_W'(j) < len_c) begin
                        if (r_kw[k][{bidx[mkm_pkg::KW_BYTE_IDX_W-1:0], 3'b000}
                                    +: mkm_pkg::BYTE_W]
                            != i_item.window[j*mkm_pkg::BYTE_W +: mkm_pkg::BYTE_W]) begin
                            hit = 1'b0;
                        end
                    end
                end
                mask[k] = hit;
            end
        end
    end

    always_comb begin
        out_free = !r_out_valid || i_pop;
        load     = !i_q_status.empty && (mask != '0) && out_free;
        o_q_pop  = !i_q_status.empty && ((mask == '0) || out_free);
        o_empty          = !r_out_valid;
        o_match_position = r_out_pos;
        o_match_mask     = r_out_mask;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_pos  <= i_item.pos;
            r_out_mask <= mask;
        end
    end

    a_valid_has_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_mask != '0))
        else $error("result held with empty mask");

    a_match_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_q_pop && (mask != '0)) |=> r_out_valid)
        else $error("matching window consumed without a result");

endmodule

@@ src/multi_keyword_match_top.sv @@
// A text byte's window goes through the window queue, then the result register, to the result ports.
// Throughput: one byte per cycle unless full; the parallel keyword compare bounds the clock.
// A four-entry window queue lets input run on while the result register waits on pop.
// Reset (synchronous, active low) clears keywords, lengths, history, count and position.
// ============================================================================
// multi_keyword_match_top: brute-force multiple keyword matching
// Streams text bytes and reports the position and mask of keyword hits.
// ============================================================================
module multi_keyword_match_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // text input transaction
    input  logic                           push,
    output logic                           full,
    input  logic [mkm_pkg::BYTE_W-1:0]     i_text_byte,
    input  logic                           i_text_start,
    // match result transaction
    output logic                           empty,
    input  logic                           pop,
    output logic [mkm_pkg::POS_W-1:0]      o_match_position,
    output logic [mkm_pkg::KW_COUNT-1:0]   o_match_mask,
    // configuration writes
    input  logic                           i_cfg_we,
    input  logic [mkm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mkm_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    mkm_pkg::t_window   front_item;
    mkm_pkg::t_window   head_item;
    mkm_pkg::t_q_status q_status;
    logic               accept;
    logic               q_pop;

    // a text transaction is taken whenever the queue has room
    assign accept = push && !q_status.full;
    assign full   = q_status.full;

    // front: history shift register, byte count and position
    mkm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_text_byte (i_text_byte),
        .i_text_start(i_text_start),
        .o_item      (front_item)
    );

    // windows wait here until the compare side takes them
    mkm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (front_item),
        .i_pop   (q_pop),
        .o_data  (head_item),
        .o_status(q_status)
    );

    // back: compare against keywords; windows without a hit are dropped
    mkm_match u_match (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_item          (head_item),
        .i_q_status      (q_status),
        .o_q_pop         (q_pop),
        .i_pop           (pop),
        .o_empty         (empty),
        .o_match_position(o_match_position),
        .o_match_mask    (o_match_mask)
    );

endmodule
